// ===== rtl/accel_axis_smoothing_framer_defines.svh =====
// Assertion helpers shared by the RTL. All checks are sampled on clk and
// are off while rst_n is low.
`ifndef ACCEL_AXIS_SMOOTHING_FRAMER_DEFINES_SVH
`define ACCEL_AXIS_SMOOTHING_FRAMER_DEFINES_SVH

// Same-cycle implication.
`define ASF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/asf_pkg.sv =====
package asf_pkg;

  localparam int unsigned FRAME_LEN = 16;
  localparam int unsigned NUM_W     = 25;  // signed sample + (d-1)*avg
  localparam int unsigned MAG_W     = 24;  // magnitude of that sum
  localparam int unsigned CNT_W     = $clog2(MAG_W + 1);

  localparam logic [7:0] DIVISOR_RESET = 8'd40;
  localparam logic [7:0] HEAD_BYTE     = 8'h03;
  localparam logic [7:0] MARK_BYTE     = 8'hFC;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_WAIT,
    ST_SEND
  } state_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/accel_axis_smoothing_framer.sv =====
// Exponential moving average over three accelerometer axes, framed as
// 16 bytes per filtered sample. The first item after reset seeds the
// averages and gives no frame; later items with sample_ok low are dropped
// with in_ready staying high. Each axis of a filtered item takes a
// multiply-add step, a divider load step, 24 steps of a 1-bit-per-cycle
// restoring divider shared by the three axes and a step that stores the
// average, with in_ready low after the accept cycle. It then presents the
// frame one byte per cycle as out_ready allows. The frame is 0x03, 0xFC,
// then per axis avg>>2 low and high byte, sample>>2 and sample>>10 low
// bytes, then 0xFC, 0x03; out_frame_last marks the final byte. A divisor
// of 0 acts as 1.
module accel_axis_smoothing_framer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic               in_sample_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_frame_byte,
  output logic               out_frame_last
);
  import asf_pkg::*;
  `include "accel_axis_smoothing_framer_defines.svh"

  state_t state_r, state_nxt;
  axis_t  axis_r;
  logic [3:0] byte_r;
  logic [7:0] div_cfg_r;
  logic [7:0] dlat_r;
  logic       seeded_r;

  logic signed [15:0] avg_x_r, avg_y_r, avg_z_r;
  logic signed [15:0] smp_x_r, smp_y_r, smp_z_r;
  logic signed [NUM_W-1:0] num_r;

  logic in_acc, out_acc, div_start;
  logic signed [15:0] cur_avg, cur_smp, avg_new;
  logic signed [8:0]  dm1;
  logic signed [NUM_W-1:0] prod, num_nxt, num_neg;
  logic [MAG_W-1:0]   div_mag, div_quot;
  logic [15:0]        q16;
  div_stat_t          div_stat;

  function automatic logic [7:0] shr2_lo(input logic [15:0] v);
    shr2_lo = v[9:2];
  endfunction

  function automatic logic [7:0] shr10_lo(input logic [15:0] v);
    shr10_lo = {v[15], v[15], v[15:10]};
  endfunction

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  always_comb begin
    case (axis_r)
      AX_X:    begin cur_avg = avg_x_r; cur_smp = smp_x_r; end
      AX_Y:    begin cur_avg = avg_y_r; cur_smp = smp_y_r; end
      AX_Z:    begin cur_avg = avg_z_r; cur_smp = smp_z_r; end
      default: begin cur_avg = avg_x_r; cur_smp = smp_x_r; end
    endcase
  end

  always_comb begin
    dm1     = signed'({1'b0, dlat_r - 8'd1});
    prod    = dm1 * cur_avg;
    num_nxt = prod + {{(NUM_W-16){cur_smp[15]}}, cur_smp};
    num_neg = -num_r;
    div_mag = num_r[NUM_W-1] ? num_neg[MAG_W-1:0] : num_r[MAG_W-1:0];
    // Truncation toward zero: divide magnitudes, restore the sign.
    q16     = div_quot[15:0];
    avg_new = num_r[NUM_W-1] ? signed'(-q16) : signed'(q16);
  end

  asf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (dlat_r),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && seeded_r && in_sample_ok) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT:  if (div_stat.done) state_nxt = (axis_r == AX_Z) ? ST_SEND : ST_MUL;
      ST_SEND:  if (out_acc && byte_r == 4'(FRAME_LEN - 1)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_START: div_start = 1'b1;
      ST_SEND:  out_valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      seeded_r  <= 1'b0;
      div_cfg_r <= DIVISOR_RESET;
      axis_r    <= AX_X;
      byte_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) div_cfg_r <= cfg_wr_data;
      if (in_acc) begin
        seeded_r <= 1'b1;
        axis_r   <= AX_X;
      end
      if (state_r == ST_WAIT && div_stat.done) begin
        case (axis_r)
          AX_X:    axis_r <= AX_Y;
          AX_Y:    axis_r <= AX_Z;
          default: axis_r <= AX_X;
        endcase
        byte_r <= '0;
      end
      if (out_acc) byte_r <= byte_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_x_r <= in_accel_x;
      smp_y_r <= in_accel_y;
      smp_z_r <= in_accel_z;
      dlat_r  <= (div_cfg_r == 8'd0) ? 8'd1 : div_cfg_r;
      // First item only seeds the averages.
      if (!seeded_r) begin
        avg_x_r <= in_accel_x;
        avg_y_r <= in_accel_y;
        avg_z_r <= in_accel_z;
      end
    end
    if (state_r == ST_MUL) num_r <= num_nxt;
    if (state_r == ST_WAIT && div_stat.done) begin
      case (axis_r)
        AX_X:    avg_x_r <= avg_new;
        AX_Y:    avg_y_r <= avg_new;
        default: avg_z_r <= avg_new;
      endcase
    end
  end

  always_comb begin
    case (byte_r)
      4'd0:    out_frame_byte = HEAD_BYTE;
      4'd1:    out_frame_byte = MARK_BYTE;
      4'd2:    out_frame_byte = shr2_lo(avg_x_r);
      4'd3:    out_frame_byte = shr10_lo(avg_x_r);
      4'd4:    out_frame_byte = shr2_lo(smp_x_r);
      4'd5:    out_frame_byte = shr10_lo(smp_x_r);
      4'd6:    out_frame_byte = shr2_lo(avg_y_r);
      4'd7:    out_frame_byte = shr10_lo(avg_y_r);
      4'd8:    out_frame_byte = shr2_lo(smp_y_r);
      4'd9:    out_frame_byte = shr10_lo(smp_y_r);
      4'd10:   out_frame_byte = shr2_lo(avg_z_r);
      4'd11:   out_frame_byte = shr10_lo(avg_z_r);
      4'd12:   out_frame_byte = shr2_lo(smp_z_r);
      4'd13:   out_frame_byte = shr10_lo(smp_z_r);
      4'd14:   out_frame_byte = MARK_BYTE;
      default: out_frame_byte = HEAD_BYTE;
    endcase
  end

  assign out_frame_last = (byte_r == 4'(FRAME_LEN - 1));

  `ASF_ASSERT_NOW(a_no_overlap, out_valid, !in_ready && !div_stat.busy, "input open while sending")
  `ASF_ASSERT_NEXT(a_frame_end, out_acc && out_frame_last, in_ready, "no return to idle after frame")
  `ASF_ASSERT_NOW(a_quot_range, div_stat.done, div_quot <= MAG_W'(32768), "average out of range")
  `ASF_ASSERT_NEXT(a_div_start, div_start, div_stat.busy, "divider did not start")

endmodule

// ===== rtl/asf_div.sv =====
module asf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [asf_pkg::MAG_W-1:0]  dividend,
  input  logic [7:0]                 divisor,
  output asf_pkg::div_stat_t         stat,
  output logic [asf_pkg::MAG_W-1:0]  quotient
);
  import asf_pkg::*;

  logic [MAG_W-1:0] dvd_r;
  logic [7:0]       rem_r;
  logic [7:0]       den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [8:0]       shifted;
  logic [9:0]       diff;
  logic             ge;
  logic [7:0]       rem_step;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    shifted  = {rem_r, dvd_r[MAG_W-1]};
    diff     = {1'b0, shifted} - {2'b00, den_r};
    ge       = ~diff[9];
    rem_step = ge ? diff[7:0] : shifted[7:0];
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = CNT_W'(MAG_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Quotient bits shift into the bottom of the dividend register.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[MAG_W-2:0], ge};
      rem_r <= rem_step;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;

endmodule
